// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the frame deframer checkers.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/lfscd_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame deframer package
// Marker bytes, status codes, controller states and the command and status
// bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package lfscd_pkg;

   localparam logic [7:0] START_A = 8'h53;
   localparam logic [7:0] START_B = 8'h59;
   localparam logic [7:0] END_A   = 8'h54;
   localparam logic [7:0] END_B   = 8'h43;

   localparam logic [1:0] STATUS_GOOD     = 2'd0;
   localparam logic [1:0] STATUS_OVERSIZE = 2'd1;
   localparam logic [1:0] STATUS_MISMATCH = 2'd2;

   typedef enum logic [3:0] {
      ST_HUNT_A,
      ST_HUNT_B,
      ST_HEADER,
      ST_BODY,
      ST_EMIT_LEN,
      ST_EMIT_SUM,
      ST_EMIT_EMPTY,
      ST_READ,
      ST_SEND
   } state_type;

   typedef enum logic [2:0] {
      OP_IDLE,
      OP_START,
      OP_SYNC,
      OP_HEADER,
      OP_BODY,
      OP_EMIT,
      OP_READ,
      OP_SEND
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] status;
   } ctl_cmd_type;

   typedef struct packed {
      logic byte_is_a;
      logic byte_is_b;
      logic header_done;
      logic oversize;
      logic body_done;
      logic frame_ok;
      logic len_zero;
      logic slot_free;
      logic replay_last;
   } dp_stat_type;

endpackage

// ===== hdl/length_framed_sum_checked_deframer_top.sv =====
// ----------------------------------------------------------------------------
// Length-framed, sum-checked deframer
// Takes one received byte per transfer and hunts for the start pair 53h 59h,
// then reads a control byte, a command byte and a big-endian 16-bit length.
// Data bytes go into a store of MAX_DATA entries, and the frame is closed by
// an 8-bit sum byte and the end pair 54h 43h. A good frame is replayed as one
// result per data byte, a bad or oversize frame yields one error result. Bytes
// are taken only in the hunt, header and body states. After the last byte of a
// frame no byte is taken until its results are loaded: a single load for an
// error or empty frame, and for a good frame a registered read of the data
// store followed by the load of the result register per data byte, each load
// waiting for a free result slot. A waiting result does not block the next
// frame's bytes. No clearing pass runs after reset.
// ----------------------------------------------------------------------------
module length_framed_sum_checked_deframer_top #(
   parameter int MAX_DATA = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_rx_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_frame_status,
   output logic [7:0]  rsp_control_code,
   output logic [7:0]  rsp_command_code,
   output logic [5:0]  rsp_data_length,
   output logic [4:0]  rsp_data_index,
   output logic [7:0]  rsp_data_byte,
   output logic        rsp_data_valid,
   output logic        rsp_last_of_run,
   output logic [15:0] rsp_good_count,
   output logic [15:0] rsp_bad_count
);
   import lfscd_pkg::*;

   ctl_cmd_type cmd;
   dp_stat_type stat;

   lfscd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   lfscd_dp #(
      .MAX_DATA (MAX_DATA)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_rx_byte      (req_rx_byte),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_ready        (rsp_ready),
      .rsp_valid        (rsp_valid),
      .rsp_frame_status (rsp_frame_status),
      .rsp_control_code (rsp_control_code),
      .rsp_command_code (rsp_command_code),
      .rsp_data_length  (rsp_data_length),
      .rsp_data_index   (rsp_data_index),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_data_valid   (rsp_data_valid),
      .rsp_last_of_run  (rsp_last_of_run),
      .rsp_good_count   (rsp_good_count),
      .rsp_bad_count    (rsp_bad_count)
   );

endmodule

// ===== hdl/lfscd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Frame deframer controller
// Tracks the frame phase and sequences header parsing, result emission and
// the replay of stored data bytes.
// ----------------------------------------------------------------------------
module lfscd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  lfscd_pkg::dp_stat_type stat,
   output lfscd_pkg::ctl_cmd_type cmd
);
   import lfscd_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      req_fire;

   assign req_ready = (state_ff == ST_HUNT_A) || (state_ff == ST_HUNT_B) ||
                      (state_ff == ST_HEADER) || (state_ff == ST_BODY);
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_HUNT_A: begin
            if (req_fire && stat.byte_is_a) state_in = ST_HUNT_B;
         end
         ST_HUNT_B: begin
            if (req_fire) begin
               if (stat.byte_is_b) state_in = ST_HEADER;
               else if (!stat.byte_is_a) state_in = ST_HUNT_A;
            end
         end
         ST_HEADER: begin
            if (req_fire && stat.header_done) begin
               state_in = stat.oversize ? ST_EMIT_LEN : ST_BODY;
            end
         end
         ST_BODY: begin
            if (req_fire && stat.body_done) begin
               if (!stat.frame_ok) state_in = ST_EMIT_SUM;
               else if (stat.len_zero) state_in = ST_EMIT_EMPTY;
               else state_in = ST_READ;
            end
         end
         ST_EMIT_LEN, ST_EMIT_SUM, ST_EMIT_EMPTY: begin
            if (stat.slot_free) state_in = ST_HUNT_A;
         end
         ST_READ: begin
            state_in = ST_SEND;
         end
         ST_SEND: begin
            if (stat.slot_free) state_in = stat.replay_last ? ST_HUNT_A : ST_READ;
         end
         default: begin
            state_in = ST_HUNT_A;
         end
      endcase
   end

   always_comb begin
      cmd.op     = OP_IDLE;
      cmd.status = STATUS_GOOD;
      case (state_ff)
         ST_HUNT_A: begin
            if (req_fire && stat.byte_is_a) cmd.op = OP_START;
         end
         ST_HUNT_B: begin
            if (req_fire) begin
               if (stat.byte_is_b) cmd.op = OP_SYNC;
               else if (stat.byte_is_a) cmd.op = OP_START;
            end
         end
         ST_HEADER: begin
            if (req_fire) cmd.op = OP_HEADER;
         end
         ST_BODY: begin
            if (req_fire) cmd.op = OP_BODY;
         end
         ST_EMIT_LEN: begin
            if (stat.slot_free) cmd.op = OP_EMIT;
            cmd.status = STATUS_OVERSIZE;
         end
         ST_EMIT_SUM: begin
            if (stat.slot_free) cmd.op = OP_EMIT;
            cmd.status = STATUS_MISMATCH;
         end
         ST_EMIT_EMPTY: begin
            if (stat.slot_free) cmd.op = OP_EMIT;
         end
         ST_READ: begin
            cmd.op = OP_READ;
         end
         ST_SEND: begin
            if (stat.slot_free) cmd.op = OP_SEND;
         end
         default: begin
            cmd.op = OP_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT_A;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== hdl/lfscd_dp.sv =====
// ----------------------------------------------------------------------------
// Frame deframer datapath
// Header and checksum registers, the data byte store, frame counters and
// the registered result slot.
// ----------------------------------------------------------------------------
module lfscd_dp #(
   parameter int MAX_DATA = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [7:0]             req_rx_byte,
   input  lfscd_pkg::ctl_cmd_type cmd,
   output lfscd_pkg::dp_stat_type stat,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_frame_status,
   output logic [7:0]             rsp_control_code,
   output logic [7:0]             rsp_command_code,
   output logic [5:0]             rsp_data_length,
   output logic [4:0]             rsp_data_index,
   output logic [7:0]             rsp_data_byte,
   output logic                   rsp_data_valid,
   output logic                   rsp_last_of_run,
   output logic [15:0]            rsp_good_count,
   output logic [15:0]            rsp_bad_count
);
   import lfscd_pkg::*;

   localparam int AW = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int LW = $clog2(MAX_DATA + 1);
   localparam int PW = $clog2(MAX_DATA + 3);

   logic [PW-1:0] pos_ff, pos_in;
   logic [7:0]    sum_ff, sum_in;
   logic [7:0]    ctrl_code_ff, ctrl_code_in;
   logic [7:0]    cmd_code_ff, cmd_code_in;
   logic [7:0]    len_hi_ff, len_hi_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    rx_sum_ff, rx_sum_in;
   logic [7:0]    end_a_ff, end_a_in;
   logic [15:0]   good_ff, good_in;
   logic [15:0]   bad_ff, bad_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    rd_data_ff;
   logic [7:0]    store_ff [MAX_DATA];

   logic          rsp_valid_ff, rsp_valid_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [5:0]    rsp_len_ff, rsp_len_in;
   logic [4:0]    rsp_idx_ff, rsp_idx_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_dvalid_ff, rsp_dvalid_in;
   logic          rsp_last_ff, rsp_last_in;
   logic [7:0]    rsp_ctrl_ff, rsp_ctrl_in;
   logic [7:0]    rsp_cmd_ff, rsp_cmd_in;
   logic [15:0]   rsp_good_ff, rsp_good_in;
   logic [15:0]   rsp_bad_ff, rsp_bad_in;

   logic [15:0]   pos_wide;
   logic [15:0]   len_wide;
   logic [15:0]   idx_wide;
   logic [15:0]   len_next;
   logic          in_data;
   logic          at_sum;
   logic          at_end_a;
   logic          load_rsp;

   assign pos_wide = 16'(pos_ff);
   assign len_wide = 16'(len_ff);
   assign idx_wide = 16'(idx_ff);
   assign len_next = {len_hi_ff, req_rx_byte};
   assign in_data  = pos_wide < len_wide;
   assign at_sum   = pos_wide == len_wide;
   assign at_end_a = pos_wide == (len_wide + 16'd1);

   assign stat.byte_is_a   = req_rx_byte == START_A;
   assign stat.byte_is_b   = req_rx_byte == START_B;
   assign stat.header_done = pos_ff == PW'(3);
   assign stat.oversize    = len_next > 16'(MAX_DATA);
   assign stat.body_done   = !in_data && !at_sum && !at_end_a;
   assign stat.frame_ok    = (rx_sum_ff == sum_ff) && (end_a_ff == END_A) &&
                             (req_rx_byte == END_B);
   assign stat.len_zero    = len_ff == '0;
   assign stat.slot_free   = !rsp_valid_ff || rsp_ready;
   assign stat.replay_last = (idx_wide + 16'd1) == len_wide;

   assign load_rsp = (cmd.op == OP_EMIT) || (cmd.op == OP_SEND);

   always_comb begin
      pos_in       = pos_ff;
      sum_in       = sum_ff;
      ctrl_code_in = ctrl_code_ff;
      cmd_code_in  = cmd_code_ff;
      len_hi_in    = len_hi_ff;
      len_in       = len_ff;
      rx_sum_in    = rx_sum_ff;
      end_a_in     = end_a_ff;
      good_in      = good_ff;
      bad_in       = bad_ff;
      idx_in       = idx_ff;
      case (cmd.op)
         OP_START: begin
            sum_in = START_A;
         end
         OP_SYNC: begin
            sum_in = sum_ff + req_rx_byte;
            pos_in = '0;
         end
         OP_HEADER: begin
            sum_in = sum_ff + req_rx_byte;
            case (pos_ff)
               PW'(0):  ctrl_code_in = req_rx_byte;
               PW'(1):  cmd_code_in  = req_rx_byte;
               PW'(2):  len_hi_in    = req_rx_byte;
               default: len_in       = len_next[LW-1:0];
            endcase
            if (stat.header_done) begin
               pos_in = '0;
               if (stat.oversize) bad_in = bad_ff + 16'd1;
            end else begin
               pos_in = pos_ff + PW'(1);
            end
         end
         OP_BODY: begin
            idx_in = '0;
            if (in_data) begin
               sum_in = sum_ff + req_rx_byte;
               pos_in = pos_ff + PW'(1);
            end else if (at_sum) begin
               rx_sum_in = req_rx_byte;
               pos_in    = pos_ff + PW'(1);
            end else if (at_end_a) begin
               end_a_in = req_rx_byte;
               pos_in   = pos_ff + PW'(1);
            end else begin
               pos_in = '0;
               if (stat.frame_ok) good_in = good_ff + 16'd1;
               else bad_in = bad_ff + 16'd1;
            end
         end
         OP_SEND: begin
            idx_in = idx_ff + AW'(1);
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_len_in    = rsp_len_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_byte_in   = rsp_byte_ff;
      rsp_dvalid_in = rsp_dvalid_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_ctrl_in   = rsp_ctrl_ff;
      rsp_cmd_in    = rsp_cmd_ff;
      rsp_good_in   = rsp_good_ff;
      rsp_bad_in    = rsp_bad_ff;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_ctrl_in  = ctrl_code_ff;
         rsp_cmd_in   = cmd_code_ff;
         rsp_good_in  = good_ff;
         rsp_bad_in   = bad_ff;
         if (cmd.op == OP_SEND) begin
            rsp_status_in = STATUS_GOOD;
            rsp_len_in    = len_wide[5:0];
            rsp_idx_in    = idx_wide[4:0];
            rsp_byte_in   = rd_data_ff;
            rsp_dvalid_in = 1'b1;
            rsp_last_in   = stat.replay_last;
         end else begin
            rsp_status_in = cmd.status;
            rsp_len_in    = '0;
            rsp_idx_in    = '0;
            rsp_byte_in   = '0;
            rsp_dvalid_in = 1'b0;
            rsp_last_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         sum_ff       <= '0;
         ctrl_code_ff <= '0;
         cmd_code_ff  <= '0;
         len_hi_ff    <= '0;
         len_ff       <= '0;
         rx_sum_ff    <= '0;
         end_a_ff     <= '0;
         good_ff      <= '0;
         bad_ff       <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         sum_ff       <= sum_in;
         ctrl_code_ff <= ctrl_code_in;
         cmd_code_ff  <= cmd_code_in;
         len_hi_ff    <= len_hi_in;
         len_ff       <= len_in;
         rx_sum_ff    <= rx_sum_in;
         end_a_ff     <= end_a_in;
         good_ff      <= good_in;
         bad_ff       <= bad_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_status_ff <= rsp_status_in;
      rsp_len_ff    <= rsp_len_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_dvalid_ff <= rsp_dvalid_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_ctrl_ff   <= rsp_ctrl_in;
      rsp_cmd_ff    <= rsp_cmd_in;
      rsp_good_ff   <= rsp_good_in;
      rsp_bad_ff    <= rsp_bad_in;
   end

   always_ff @(posedge clock) begin
      if ((cmd.op == OP_BODY) && in_data) begin
         store_ff[pos_ff[AW-1:0]] <= req_rx_byte;
      end
      if (cmd.op == OP_READ) begin
         rd_data_ff <= store_ff[idx_ff];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_frame_status = rsp_status_ff;
   assign rsp_control_code = rsp_ctrl_ff;
   assign rsp_command_code = rsp_cmd_ff;
   assign rsp_data_length  = rsp_len_ff;
   assign rsp_data_index   = rsp_idx_ff;
   assign rsp_data_byte    = rsp_byte_ff;
   assign rsp_data_valid   = rsp_dvalid_ff;
   assign rsp_last_of_run  = rsp_last_ff;
   assign rsp_good_count   = rsp_good_ff;
   assign rsp_bad_count    = rsp_bad_ff;

endmodule

// ===== hdl/lfscd_checker.sv =====
// ----------------------------------------------------------------------------
// Frame deframer checker
// Port-level checks on the request and result channels, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module lfscd_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [7:0]  req_rx_byte,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_frame_status,
   input logic [7:0]  rsp_control_code,
   input logic [7:0]  rsp_command_code,
   input logic [5:0]  rsp_data_length,
   input logic [4:0]  rsp_data_index,
   input logic [7:0]  rsp_data_byte,
   input logic        rsp_data_valid,
   input logic        rsp_last_of_run,
   input logic [15:0] rsp_good_count,
   input logic [15:0] rsp_bad_count
);
   import lfscd_pkg::*;

   `ASSERT_NEXT(a_req_hold, clock, reset, req_valid && !req_ready, req_valid && $stable(req_rx_byte), "request changed while stalled")
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable({rsp_data_byte, rsp_data_index, rsp_frame_status, rsp_control_code, rsp_command_code, rsp_good_count, rsp_bad_count}), "result changed while stalled")
   `ASSERT_IMPLIES(a_data_good, clock, reset, rsp_valid && rsp_data_valid, rsp_frame_status == STATUS_GOOD, "data byte carried by a failed frame")
   `ASSERT_IMPLIES(a_nodata_last, clock, reset, rsp_valid && !rsp_data_valid, rsp_last_of_run && (rsp_data_index == 5'd0) && (rsp_data_byte == 8'd0), "result without data is not a single closing result")
   `ASSERT_IMPLIES(a_err_len, clock, reset, rsp_valid && (rsp_frame_status != STATUS_GOOD), (rsp_data_length == 6'd0) && !rsp_data_valid, "error result reports data")

endmodule

bind length_framed_sum_checked_deframer_top lfscd_checker u_checker (.*);

// ===== bench/length_framed_sum_checked_deframer_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer testbench
// Feeds the deframer byte streams of whole, damaged, oversize, cut-short and
// noise frames, with random sender bursts and receiver stalls. A shadow model
// predicts every result from the accepted bytes, and each result transfer is
// checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module length_framed_sum_checked_deframer_top_test;
   import lfscd_pkg::*;

   localparam int MAX_DATA       = 32;
   localparam int RANDOM_BYTES   = 340;
   localparam int LONG_HOLD      = 300;
   localparam int TAIL_CYCLES    = 2 * MAX_DATA + 16;
   localparam int WATCHDOG_LIMIT = 4000;

   typedef struct packed {
      logic [1:0]  frame_status;
      logic [7:0]  control_code;
      logic [7:0]  command_code;
      logic [5:0]  data_length;
      logic [4:0]  data_index;
      logic [7:0]  data_byte;
      logic        data_valid;
      logic        last_of_run;
      logic [15:0] good_count;
      logic [15:0] bad_count;
   } frame_result_type;

   class deframer_shadow;
      state_type        hunt_state;
      int               pos;
      logic [7:0]       frame_ctl;
      logic [7:0]       frame_cmd;
      logic [15:0]      frame_len;
      logic [7:0]       sum_acc;
      logic [7:0]       sum_seen;
      logic [7:0]       tail_first;
      logic [7:0]       body_mem [MAX_DATA];
      logic [15:0]      good_total;
      logic [15:0]      bad_total;
      frame_result_type due_results [$];
      int               mismatches;

      function new();
         hunt_state = ST_HUNT_A;
         pos = 0;
         frame_ctl = '0;
         frame_cmd = '0;
         frame_len = '0;
         sum_acc = '0;
         sum_seen = '0;
         tail_first = '0;
         good_total = '0;
         bad_total = '0;
         mismatches = 0;
      endfunction

      function void queue_result(logic [1:0] status, logic [5:0] len, logic [4:0] idx,
                                 logic [7:0] value, logic dv, logic last);
         due_results.push_back('{status, frame_ctl, frame_cmd, len, idx, value, dv, last,
                                 good_total, bad_total});
      endfunction

      function void note_byte(logic [7:0] b);
         logic ok;
         case (hunt_state)
            ST_HUNT_A: begin
               if (b == START_A) begin
                  sum_acc = START_A;
                  hunt_state = ST_HUNT_B;
               end
            end
            ST_HUNT_B: begin
               if (b == START_B) begin
                  sum_acc = sum_acc + b;
                  pos = 0;
                  hunt_state = ST_HEADER;
               end else if (b == START_A) begin
                  sum_acc = START_A;
               end else begin
                  hunt_state = ST_HUNT_A;
               end
            end
            ST_HEADER: begin
               sum_acc = sum_acc + b;
               case (pos)
                  0: frame_ctl = b;
                  1: frame_cmd = b;
                  2: frame_len = {b, 8'h00};
                  default: frame_len = frame_len | {8'h00, b};
               endcase
               pos++;
               if (pos >= 4) begin
                  pos = 0;
                  if (frame_len > MAX_DATA) begin
                     bad_total++;
                     queue_result(STATUS_OVERSIZE, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1);
                     hunt_state = ST_HUNT_A;
                  end else begin
                     hunt_state = ST_BODY;
                  end
               end
            end
            default: begin
               if (pos < frame_len) begin
                  body_mem[pos] = b;
                  sum_acc = sum_acc + b;
                  pos++;
               end else if (pos == frame_len) begin
                  sum_seen = b;
                  pos++;
               end else if (pos == frame_len + 1) begin
                  tail_first = b;
                  pos++;
               end else begin
                  ok = (sum_seen == sum_acc) && (tail_first == END_A) && (b == END_B);
                  if (ok) begin
                     good_total++;
                     if (frame_len == 0)
                        queue_result(STATUS_GOOD, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1);
                     for (int i = 0; i < frame_len; i++)
                        queue_result(STATUS_GOOD, frame_len[5:0], i[4:0], body_mem[i], 1'b1,
                                     i + 1 == frame_len);
                  end else begin
                     bad_total++;
                     queue_result(STATUS_MISMATCH, 6'd0, 5'd0, 8'h00, 1'b0, 1'b1);
                  end
                  pos = 0;
                  hunt_state = ST_HUNT_A;
               end
            end
         endcase
      endfunction

      function string show(frame_result_type r);
         return $sformatf({"status=%0d ctl=%02h cmd=%02h len=%0d idx=%0d byte=%02h",
                           " dv=%0b last=%0b good=%0d bad=%0d"},
                          r.frame_status, r.control_code, r.command_code, r.data_length,
                          r.data_index, r.data_byte, r.data_valid, r.last_of_run,
                          r.good_count, r.bad_count);
      endfunction

      function void check_result(frame_result_type got);
         frame_result_type want;
         string diffs;
         if (due_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: %s", show(got));
            return;
         end
         want = due_results.pop_front();
         diffs = "";
         if (got.frame_status !== want.frame_status) diffs = {diffs, " frame_status"};
         if (got.control_code !== want.control_code) diffs = {diffs, " control_code"};
         if (got.command_code !== want.command_code) diffs = {diffs, " command_code"};
         if (got.data_length !== want.data_length) diffs = {diffs, " data_length"};
         if (got.data_index !== want.data_index) diffs = {diffs, " data_index"};
         if (got.data_byte !== want.data_byte) diffs = {diffs, " data_byte"};
         if (got.data_valid !== want.data_valid) diffs = {diffs, " data_valid"};
         if (got.last_of_run !== want.last_of_run) diffs = {diffs, " last_of_run"};
         if (got.good_count !== want.good_count) diffs = {diffs, " good_count"};
         if (got.bad_count !== want.bad_count) diffs = {diffs, " bad_count"};
         if (diffs != "") begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("mismatch in%s", diffs);
               $display("   expected %s", show(want));
               $display("   actual   %s", show(got));
            end
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_frame_status;
   logic [7:0]  rsp_control_code;
   logic [7:0]  rsp_command_code;
   logic [5:0]  rsp_data_length;
   logic [4:0]  rsp_data_index;
   logic [7:0]  rsp_data_byte;
   logic        rsp_data_valid;
   logic        rsp_last_of_run;
   logic [15:0] rsp_good_count;
   logic [15:0] rsp_bad_count;

   deframer_shadow shadow = new();
   bit             hold_request = 1'b0;
   bit             req_offering = 1'b0;
   bit             steady = 1'b0;
   int             burst_left = 1;
   int             frame_bytes = 0;
   int             idle_edges = 0;

   length_framed_sum_checked_deframer_top #(
      .MAX_DATA(MAX_DATA)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_rx_byte(req_rx_byte),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_frame_status(rsp_frame_status),
      .rsp_control_code(rsp_control_code),
      .rsp_command_code(rsp_command_code),
      .rsp_data_length(rsp_data_length),
      .rsp_data_index(rsp_data_index),
      .rsp_data_byte(rsp_data_byte),
      .rsp_data_valid(rsp_data_valid),
      .rsp_last_of_run(rsp_last_of_run),
      .rsp_good_count(rsp_good_count),
      .rsp_bad_count(rsp_bad_count)
   );

   always #4 clock = ~clock;

   always @(posedge clock) begin
      frame_result_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            shadow.note_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_frame_status, rsp_control_code, rsp_command_code, rsp_data_length,
                    rsp_data_index, rsp_data_byte, rsp_data_valid, rsp_last_of_run,
                    rsp_good_count, rsp_bad_count};
            shadow.check_result(got);
         end
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_edges = 0;
         end else begin
            idle_edges++;
            if (idle_edges >= WATCHDOG_LIMIT) begin
               $display("Testbench completed WITH ERRORS");
               $finish;
            end
         end
      end
   end

   initial begin : receiver
      int mode;
      wait (!reset);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end else begin
            mode = $urandom_range(0, 3);
            rsp_ready <= (mode != 0);
            repeat (mode == 0 ? $urandom_range(1, 6) : $urandom_range(1, 30))
               @(posedge clock);
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      req_valid <= 1'b1;
      req_rx_byte <= b;
      req_offering = 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic go_idle(input int cycles);
      if (req_offering) begin
         req_valid <= 1'b0;
         req_offering = 1'b0;
      end
      repeat (cycles) @(posedge clock);
   endtask

   task automatic offer_byte(input logic [7:0] b);
      send_byte(b);
      if (!steady) begin
         burst_left--;
         if (burst_left <= 0) begin
            go_idle($urandom_range(1, 10));
            burst_left = $urandom_range(1, 16);
         end
      end
   endtask

   task automatic send_frame(input logic [7:0] ctl, input logic [7:0] cmd,
                             input logic [15:0] len, input logic [7:0] sum_flip,
                             input logic [7:0] tail_a, input logic [7:0] tail_b,
                             input int cut);
      logic [7:0] frame [$];
      logic [7:0] sum;
      frame = {START_A, START_B, ctl, cmd, len[15:8], len[7:0]};
      if (len <= MAX_DATA) begin
         for (int i = 0; i < len; i++)
            frame.push_back(8'($urandom_range(0, 255)));
         sum = 8'h00;
         foreach (frame[i])
            sum = sum + frame[i];
         frame.push_back(sum ^ sum_flip);
         frame.push_back(tail_a);
         frame.push_back(tail_b);
      end
      if (cut > 0 && cut < frame.size())
         frame = frame[0:cut-1];
      foreach (frame[i])
         offer_byte(frame[i]);
      frame_bytes += frame.size();
   endtask

   task automatic drain_results();
      go_idle(1);
      while (shadow.due_results.size() != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [7:0]  ctl;
      logic [7:0]  cmd;
      logic [15:0] len;
      int          pick;
      bit          halfway_drained;
      halfway_drained = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      offer_byte(8'h00);
      offer_byte(8'hFF);
      offer_byte(START_A);
      offer_byte(8'h00);
      offer_byte(START_A);
      offer_byte(START_A);
      send_frame(8'hFF, 8'h00, 16'd0, 8'h00, END_A, END_B, 0);
      send_frame(8'h00, 8'hFF, 16'd1, 8'h00, END_A, END_B, 0);
      send_frame(8'hA5, 8'h5A, 16'(MAX_DATA), 8'h00, END_A, END_B, 0);
      send_frame(8'h01, 8'h02, 16'(MAX_DATA + 1), 8'h00, END_A, END_B, 0);
      send_frame(8'h80, 8'h7F, 16'hFFFF, 8'h00, END_A, END_B, 0);
      send_frame(8'h11, 8'h22, 16'd3, 8'h01, END_A, END_B, 0);
      send_frame(8'h33, 8'h44, 16'd2, 8'h00, 8'h00, END_B, 0);
      send_frame(8'h55, 8'h66, 16'd0, 8'h00, END_A, 8'hFF, 0);
      drain_results();

      hold_request = 1'b1;
      frame_bytes = 0;
      while (frame_bytes < RANDOM_BYTES) begin
         steady = ($urandom_range(0, 4) == 0);
         pick = $urandom_range(0, 99);
         ctl = 8'($urandom_range(0, 255));
         cmd = 8'($urandom_range(0, 255));
         len = ($urandom_range(0, 9) == 0) ? 16'($urandom_range(0, MAX_DATA))
                                           : 16'($urandom_range(0, 8));
         if (pick < 65)
            send_frame(ctl, cmd, len, 8'h00, END_A, END_B, 0);
         else if (pick < 72)
            send_frame(ctl, cmd, len, 8'($urandom_range(1, 255)), END_A, END_B, 0);
         else if (pick < 78)
            send_frame(ctl, cmd, len, 8'h00, 8'($urandom_range(0, 255)),
                       8'($urandom_range(0, 255)), 0);
         else if (pick < 85)
            send_frame(ctl, cmd, 16'($urandom_range(MAX_DATA + 1, 65535)), 8'h00,
                       END_A, END_B, 0);
         else if (pick < 90)
            send_frame(ctl, cmd, len, 8'h00, END_A, END_B,
                       $urandom_range(1, 8 + int'(len)));
         else
            repeat ($urandom_range(1, 4)) offer_byte(8'($urandom_range(0, 255)));
         if (!halfway_drained && frame_bytes >= RANDOM_BYTES / 2) begin
            halfway_drained = 1'b1;
            drain_results();
         end
      end
      steady = 1'b0;

      drain_results();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.due_results.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/lfscd_pkg.sv
hdl/lfscd_ctrl.sv
hdl/lfscd_dp.sv
hdl/length_framed_sum_checked_deframer_top.sv
hdl/lfscd_checker.sv
bench/length_framed_sum_checked_deframer_top_test.sv
